FILE: hw/rtl/positional_array_list_assert.svh
// assertion macros for the positional array list
// no dependencies; included by positional_array_list, which checks itself
`ifndef POSITIONAL_ARRAY_LIST_ASSERT_SVH
`define POSITIONAL_ARRAY_LIST_ASSERT_SVH

`ifndef SYNTH
`define PAL_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("positional_array_list assertion failed");
`define PAL_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("positional_array_list reset assertion failed");
`else
`define PAL_ASSERT(lbl, clk, rst_n, prop)
`define PAL_ASSERT_RST(lbl, clk, prop)
`endif

`endif

FILE: hw/rtl/pal_pkg.sv
// shared types and constants for the positional array list
// no dependencies; imported by pal_cell and positional_array_list
package pal_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    localparam int POS_W    = 8;
    localparam int VAL_W    = 32;
    localparam int FOUND_W  = 6;
    localparam int ECOUNT_W = 7;

    typedef enum logic [2:0] {
        CMD_CLEAR  = 3'd0,
        CMD_INSERT = 3'd1,
        CMD_DELETE = 3'd2,
        CMD_SEARCH = 3'd3,
        CMD_READ   = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_POS   = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef struct packed {
        logic               ins;
        logic               del;
        logic [POS_W-1:0]   pos;
        logic [COUNT_W-1:0] count;
        logic [VAL_W-1:0]   value;
    } t_cell_ctl;

endpackage

FILE: hw/rtl/pal_cell.sv
// one list slot: holds an entry, shifts with its neighbors, compares for search
// depends on pal_pkg
module pal_cell
    import pal_pkg::*;
(
    input  logic             i_clk,
    input  t_cell_ctl        i_ctl,
    input  logic [IDX_W-1:0] i_index,
    input  logic [VAL_W-1:0] i_left,
    input  logic [VAL_W-1:0] i_right,
    output logic [VAL_W-1:0] o_entry,
    output logic             o_match
);

    logic [VAL_W-1:0] r_entry;
    logic [VAL_W-1:0] n_entry;
    logic [POS_W-1:0] w_idx_pos;

    assign w_idx_pos = POS_W'(i_index);

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins) begin
            if (w_idx_pos == i_ctl.pos) begin
                n_entry = i_ctl.value;
            end else if (w_idx_pos > i_ctl.pos) begin
                n_entry = i_left;
            end
        end else if (i_ctl.del && (w_idx_pos >= i_ctl.pos)) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_match = (COUNT_W'(i_index) < i_ctl.count) && (r_entry == i_ctl.value);

endmodule

FILE: hw/rtl/positional_array_list.sv
// positional array list: ordered list of signed words in a chain of cells
// the result word is registered and valid in the cycle after the command word is accepted
// throughput: one command per cycle while the output is not stalled; every cell shifts and compares in that cycle
// reset clears the entry count and the output valid; slot contents stay unknown
// depends on pal_pkg, pal_cell and positional_array_list_assert.svh
`include "positional_array_list_assert.svh"
module positional_array_list
    import pal_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [2:0]                 i_cmd,
    input  logic [POS_W-1:0]           i_position,
    input  logic signed [VAL_W-1:0]    i_item_value,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [1:0]                 o_status,
    output logic [FOUND_W-1:0]         o_found_index,
    output logic signed [VAL_W-1:0]    o_read_value,
    output logic [ECOUNT_W-1:0]        o_entry_count
);

    logic [COUNT_W-1:0]  r_count;
    logic [COUNT_W-1:0]  n_count;
    logic                r_out_valid;
    t_status             r_status;
    logic [FOUND_W-1:0]  r_found;
    logic [VAL_W-1:0]    r_read;
    logic [ECOUNT_W-1:0] r_ecount;

    logic                w_accept;
    logic                w_ins_ok;
    logic                w_del_ok;
    t_status             w_status;
    logic [IDX_W-1:0]    w_found;
    logic [VAL_W-1:0]    w_read;
    logic                w_hit;
    logic [IDX_W-1:0]    w_first;
    t_cell_ctl           w_ctl;
    logic [VAL_W-1:0]    w_entry [CAPACITY];
    logic [CAPACITY-1:0] w_match;

    assign o_stall  = r_out_valid & i_stall;
    assign w_accept = i_valid & ~o_stall;

    assign w_ctl.ins   = w_accept & w_ins_ok;
    assign w_ctl.del   = w_accept & w_del_ok;
    assign w_ctl.pos   = i_position;
    assign w_ctl.count = r_count;
    assign w_ctl.value = i_item_value;

    // cell chain
    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic [VAL_W-1:0] w_left;
            logic [VAL_W-1:0] w_right;
            if (g == 0) begin : g_first
                assign w_left = '0;
            end else begin : g_mid_l
                assign w_left = w_entry[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign w_right = '0;
            end else begin : g_mid_r
                assign w_right = w_entry[g+1];
            end
            pal_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_index (IDX_W'(g)),
                .i_left  (w_left),
                .i_right (w_right),
                .o_entry (w_entry[g]),
                .o_match (w_match[g])
            );
        end
    endgenerate

    // first match wins
    always_comb begin
        w_hit   = 1'b0;
        w_first = '0;
        for (int k = CAPACITY - 1; k >= 0; k--) begin
            if (w_match[k]) begin
                w_hit   = 1'b1;
                w_first = IDX_W'(k);
            end
        end
    end

    always_comb begin
        n_count  = r_count;
        w_status = ST_OK;
        w_found  = '0;
        w_read   = '0;
        w_ins_ok = 1'b0;
        w_del_ok = 1'b0;
        case (t_cmd'(i_cmd))
            CMD_CLEAR: begin
                n_count = '0;
            end
            CMD_INSERT: begin
                if (i_position > POS_W'(r_count)) begin
                    w_status = ST_BAD_POS;
                end else if (r_count >= COUNT_W'(CAPACITY)) begin
                    w_status = ST_FULL;
                end else begin
                    w_ins_ok = 1'b1;
                    n_count  = r_count + 1'b1;
                end
            end
            CMD_DELETE: begin
                if (i_position >= POS_W'(r_count)) begin
                    w_status = ST_BAD_POS;
                end else begin
                    w_del_ok = 1'b1;
                    n_count  = r_count - 1'b1;
                end
            end
            CMD_SEARCH: begin
                if (w_hit) begin
                    w_found = w_first;
                end else begin
                    w_status = ST_NOT_FOUND;
                end
            end
            CMD_READ: begin
                if (i_position >= POS_W'(r_count)) begin
                    w_status = ST_BAD_POS;
                end else begin
                    w_read = w_entry[i_position[IDX_W-1:0]];
                end
            end
            default: begin
                w_status = ST_BAD_POS;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= w_status;
            r_found  <= FOUND_W'(w_found);
            r_read   <= w_read;
            r_ecount <= ECOUNT_W'(n_count);
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_found_index = r_found;
    assign o_read_value  = r_read;
    assign o_entry_count = r_ecount;

    `PAL_ASSERT(a_count_in_range, i_clk, i_rst_n, r_count <= COUNT_W'(CAPACITY))
    `PAL_ASSERT(a_insert_grows, i_clk, i_rst_n, w_ctl.ins |=> r_count == $past(r_count) + 1'b1)
    `PAL_ASSERT(a_delete_shrinks, i_clk, i_rst_n, w_ctl.del |=> r_count == $past(r_count) - 1'b1)
    `PAL_ASSERT(a_count_matches_out, i_clk, i_rst_n, w_accept |=> o_entry_count == ECOUNT_W'(r_count))
    `PAL_ASSERT_RST(a_reset_empty, i_clk, !i_rst_n |=> !o_valid && r_count == '0)

endmodule
